>>> rtl/atqs_pkg.sv
// ---------------------------------------------------------------------------
// atqs_pkg: shared types and constants of the textured quad shader
// fixed field widths, request codes, register indexes and channel scaling
// ---------------------------------------------------------------------------
package atqs_pkg;

  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 4;
  localparam int SCREEN_BITS = 10;
  localparam int INDEX_BITS  = 12;
  localparam int COLOR_BITS  = 32;
  localparam int SIZE_BITS   = 7;

  // corner differences and pixel offsets
  localparam int DIFF_W = ((SCREEN_BITS + FRAC_BITS > COORD_BITS) ?
                           SCREEN_BITS + FRAC_BITS : COORD_BITS) + 1;
  localparam int PROD_W = 2 * DIFF_W;
  // cross product differences, with headroom for negation
  localparam int SUM_W  = PROD_W + 2;
  // magnitude of the determinant, unsigned
  localparam int DEN_W  = SUM_W - 1;
  // 50*n and 51*d range test operands
  localparam int RNG_W  = SUM_W + 6;

  // |det| * 1000 >= 2^(2*frac) rewritten as a plain lower bound on |det|
  localparam int DET_MIN = ((1 << (2 * FRAC_BITS)) + 999) / 1000;

  localparam logic [7:0] ALPHA_MIN = 8'd10;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_SHADE = 1'b1;

  localparam logic [1:0] REG_TEX_WIDTH  = 2'd0;
  localparam logic [1:0] REG_TEX_HEIGHT = 2'd1;

  typedef struct packed {
    logic                   typ;
    logic [SCREEN_BITS-1:0] px;
    logic [SCREEN_BITS-1:0] py;
    logic [INDEX_BITS-1:0]  idx;
    logic [COLOR_BITS-1:0]  col;
    logic [7:0]             br;
  } req_t;

  // ch * br / 255, exact for products up to 255*255
  function automatic logic [7:0] shade(input logic [7:0] ch, input logic [7:0] br);
    logic [15:0] p;
    logic [16:0] s;
    p = ch * br;
    s = 17'(p) + 17'd1 + 17'(p[15:8]);
    return s[15:8];
  endfunction

endpackage

>>> rtl/atqs_ram.sv
// ---------------------------------------------------------------------------
// atqs_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module atqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/atqs_div.sv
// ---------------------------------------------------------------------------
// atqs_div: pipelined restoring divider
// one quotient bit per stage, quotient known to fit in QW bits
// ---------------------------------------------------------------------------
module atqs_div
  import atqs_pkg::*;
#(
  parameter int QW = 6
) (
  input  logic                clk,
  input  logic                en,
  input  logic [DEN_W+QW-1:0] num,
  input  logic [DEN_W-1:0]    den,
  output logic [QW-1:0]       quo
);

  logic [DEN_W+QW-1:0] rem [QW];
  logic [DEN_W-1:0]    dd  [QW];
  logic [QW-1:0]       qq  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int B = QW - 1 - k;
    localparam logic [QW-1:0] BIT = QW'(1) << B;
    logic [DEN_W+QW-1:0] rin;
    logic [DEN_W-1:0]    din;
    logic [QW-1:0]       qin;
    logic [DEN_W+QW-1:0] sub;
    logic                ge;

    if (k == 0) begin : g_first
      assign rin = num;
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem[k-1];
      assign din = dd[k-1];
      assign qin = qq[k-1];
    end

    assign sub = (DEN_W+QW)'(din) << B;
    assign ge  = (rin >= sub);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? rin - sub : rin;
        dd[k]  <= din;
        qq[k]  <= ge ? (qin | BIT) : qin;
      end
    end
  end

  assign quo = qq[QW-1];

endmodule

>>> rtl/affine_textured_quad_shader.sv
// ---------------------------------------------------------------------------
// affine_textured_quad_shader: affine texture lookup for one quad pixel
// texel loads and pixel shading share one stream, texture held in a ram
// ---------------------------------------------------------------------------
// usage:
//   s_* carries requests; tuser selects a texel write (0) or a pixel shade (1)
//   m_* returns exactly one result per request, tuser = pixel write flag
//   cfg_* writes the texture width (index 0) and height (index 1); cfg_ready
//   is high outside reset, write only while the stream is empty
// throughput: one request per cycle, sustained while m_tready lets the output register move
// pipeline: six product and range stages, one divider stage per texel
//   coordinate bit, the ram read and the output register
// stall: the whole pipeline advances only when the output register is empty
//   or taken, so s_tready follows m_tready and nothing is dropped
// reset: clears all valid bits and sets width and height to 16; the texture
//   ram is not cleared and must be loaded before texels are read; s_tready
//   and cfg_ready stay low while rst is high
// texel writes go to the ram in the same stage where shades read it, so
//   results follow the request order with no forwarding needed
// ---------------------------------------------------------------------------
module affine_textured_quad_shader
  import atqs_pkg::*;
#(
  parameter int TEX_MAX_SIDE = 64
) (
  input  logic         clk,
  input  logic         rst,
  // pixel_x, pixel_y, texel_index, texel_color, origin_x, origin_y,
  // edge_u_end_x, edge_u_end_y, edge_v_end_x, edge_v_end_y, brightness
  input  logic [167:0] s_tdata,
  // req_type
  input  logic         s_tuser,
  input  logic         s_tvalid,
  output logic         s_tready,
  // out_x, out_y, out_color, zero pad
  output logic [55:0]  m_tdata,
  // pixel_write
  output logic         m_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [6:0]   cfg_data
);

  localparam int DEPTH = TEX_MAX_SIDE * TEX_MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int QW    = $clog2(TEX_MAX_SIDE);
  localparam int SW    = $clog2(TEX_MAX_SIDE + 1);
  localparam int NW    = DEN_W + QW;

  // configuration registers
  logic [SIZE_BITS-1:0] tex_width;
  logic [SIZE_BITS-1:0] tex_height;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= SIZE_BITS'(16);
      tex_height <= SIZE_BITS'(16);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TEX_WIDTH:  tex_width  <= cfg_data;
        REG_TEX_HEIGHT: tex_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes clamped to [1, TEX_MAX_SIDE]
  logic [SW-1:0] eff_w, eff_h;
  logic [QW-1:0] mw, mh;

  assign eff_w = (tex_width == '0) ? SW'(1) :
                 (32'(tex_width) > TEX_MAX_SIDE) ? SW'(TEX_MAX_SIDE) : SW'(tex_width);
  assign eff_h = (tex_height == '0) ? SW'(1) :
                 (32'(tex_height) > TEX_MAX_SIDE) ? SW'(TEX_MAX_SIDE) : SW'(tex_height);
  assign mw = QW'(eff_w - SW'(1));
  assign mh = QW'(eff_h - SW'(1));

  // global advance: the output register is empty or being taken
  logic adv;
  logic o_v;

  assign adv      = !o_v || m_tready;
  assign s_tready = adv && !rst;

  // input unpacking
  req_t                    in_req;
  logic signed [COORD_BITS-1:0] ox, oy, ux, uy, vx, vy;

  assign in_req.typ = s_tuser;
  assign in_req.px  = s_tdata[9:0];
  assign in_req.py  = s_tdata[19:10];
  assign in_req.idx = s_tdata[31:20];
  assign in_req.col = s_tdata[63:32];
  assign in_req.br  = s_tdata[167:160];
  assign ox = s_tdata[79:64];
  assign oy = s_tdata[95:80];
  assign ux = s_tdata[111:96];
  assign uy = s_tdata[127:112];
  assign vx = s_tdata[143:128];
  assign vy = s_tdata[159:144];

  // stage a: edge vectors and pixel offset from the origin
  logic                     a_v;
  req_t                     a_req;
  logic signed [DIFF_W-1:0] a_e0x, a_e0y, a_e1x, a_e1y, a_dx, a_dy;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_req <= in_req;
      a_e0x <= DIFF_W'(ux) - DIFF_W'(ox);
      a_e0y <= DIFF_W'(uy) - DIFF_W'(oy);
      a_e1x <= DIFF_W'(vx) - DIFF_W'(ox);
      a_e1y <= DIFF_W'(vy) - DIFF_W'(oy);
      a_dx  <= $signed(DIFF_W'({in_req.px, FRAC_BITS'(0)})) - DIFF_W'(ox);
      a_dy  <= $signed(DIFF_W'({in_req.py, FRAC_BITS'(0)})) - DIFF_W'(oy);
    end
  end

  // stage b: the six cross products
  logic                     b_v;
  req_t                     b_req;
  logic signed [PROD_W-1:0] b_pa, b_pb, b_pc, b_pd, b_pe, b_pf;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_req <= a_req;
      b_pa  <= a_e0x * a_e1y;
      b_pb  <= a_e0y * a_e1x;
      b_pc  <= a_dx * a_e1y;
      b_pd  <= a_dy * a_e1x;
      b_pe  <= a_e0x * a_dy;
      b_pf  <= a_e0y * a_dx;
    end
  end

  // stage c: determinant and the two numerators
  logic                    c_v;
  req_t                    c_req;
  logic signed [SUM_W-1:0] c_det, c_nu, c_nv;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_req <= b_req;
      c_det <= SUM_W'(b_pa) - SUM_W'(b_pb);
      c_nu  <= SUM_W'(b_pc) - SUM_W'(b_pd);
      c_nv  <= SUM_W'(b_pe) - SUM_W'(b_pf);
    end
  end

  // stage d: fold the sign of the determinant into the numerators
  logic                    d_v;
  req_t                    d_req;
  logic signed [SUM_W-1:0] d_adet, d_nu, d_nv;
  logic                    d_ok;
  logic signed [SUM_W-1:0] abs_det;

  assign abs_det = c_det[SUM_W-1] ? -c_det : c_det;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_req  <= c_req;
      d_adet <= abs_det;
      d_nu   <= c_det[SUM_W-1] ? -c_nu : c_nu;
      d_nv   <= c_det[SUM_W-1] ? -c_nv : c_nv;
      // degenerate quads draw nothing
      d_ok   <= (abs_det >= SUM_W'(DET_MIN));
    end
  end

  // stage e: range test operands and clamped numerators
  logic                    e_v;
  req_t                    e_req;
  logic                    e_ok;
  logic signed [RNG_W-1:0] e_nu50, e_nv50, e_dneg, e_d51;
  logic [DEN_W-1:0]        e_cu, e_cv, e_den;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_req  <= d_req;
      e_ok   <= d_ok;
      e_nu50 <= RNG_W'(d_nu) * RNG_W'(50);
      e_nv50 <= RNG_W'(d_nv) * RNG_W'(50);
      e_dneg <= -RNG_W'(d_adet);
      e_d51  <= RNG_W'(d_adet) * RNG_W'(51);
      e_den  <= DEN_W'(d_adet);
      e_cu   <= d_nu[SUM_W-1] ? '0 : (d_nu > d_adet) ? DEN_W'(d_adet) : DEN_W'(d_nu);
      e_cv   <= d_nv[SUM_W-1] ? '0 : (d_nv > d_adet) ? DEN_W'(d_adet) : DEN_W'(d_nv);
    end
  end

  // stage f: inside test for [-0.02, 1.02] and scaled numerators
  logic             f_v;
  req_t             f_req;
  logic             f_draw;
  logic [NW-1:0]    f_numu, f_numv;
  logic [DEN_W-1:0] f_den;

  always_ff @(posedge clk) begin
    if (adv) begin
      f_req  <= e_req;
      f_draw <= e_ok && (e_nu50 >= e_dneg) && (e_nu50 <= e_d51) &&
                (e_nv50 >= e_dneg) && (e_nv50 <= e_d51);
      f_numu <= NW'(e_cu) * NW'(mw);
      f_numv <= NW'(e_cv) * NW'(mh);
      f_den  <= e_den;
    end
  end

  // texel column and row, one bit per divider stage
  logic [QW-1:0] quo_u, quo_v;

  atqs_div #(.QW(QW)) u_div_u (
    .clk (clk),
    .en  (adv),
    .num (f_numu),
    .den (f_den),
    .quo (quo_u)
  );

  atqs_div #(.QW(QW)) u_div_v (
    .clk (clk),
    .en  (adv),
    .num (f_numv),
    .den (f_den),
    .quo (quo_v)
  );

  // request delay line beside the dividers
  logic dly_v    [QW];
  req_t dly_req  [QW];
  logic dly_draw [QW];

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_req[0]  <= f_req;
      dly_draw[0] <= f_draw;
      for (int i = 1; i < QW; i++) begin
        dly_req[i]  <= dly_req[i-1];
        dly_draw[i] <= dly_draw[i-1];
      end
    end
  end

  // stage g: texture address, ram write and read issue
  req_t          g_req;
  logic          g_v;
  logic [QW-1:0] sx, sy;
  logic [AW-1:0] rd_addr;
  logic [31:0]   idx_wide;
  logic          tex_we;

  assign g_req    = dly_req[QW-1];
  assign g_v      = dly_v[QW-1];
  assign sx       = (quo_u > mw) ? mw : quo_u;
  assign sy       = (quo_v > mh) ? mh : quo_v;
  assign rd_addr  = AW'(sy) * AW'(eff_w) + AW'(sx);
  assign idx_wide = 32'(g_req.idx);
  // writes beyond the store are dropped
  assign tex_we   = adv && g_v && (g_req.typ == REQ_WRITE) && (idx_wide < DEPTH);

  logic [COLOR_BITS-1:0] texel;

  atqs_ram #(.WIDTH(COLOR_BITS), .DEPTH(DEPTH)) u_tex_ram (
    .clk   (clk),
    .we    (tex_we),
    .waddr (idx_wide[AW-1:0]),
    .wdata (g_req.col),
    .re    (adv),
    .raddr (rd_addr),
    .rdata (texel)
  );

  // stage h: texel arrives from the ram
  logic h_v;
  req_t h_req;
  logic h_draw;

  always_ff @(posedge clk) begin
    if (adv) begin
      h_req  <= g_req;
      h_draw <= dly_draw[QW-1];
    end
  end

  // output register: alpha test and brightness scaling
  logic                   o_write;
  logic [SCREEN_BITS-1:0] o_x, o_y;
  logic [COLOR_BITS-1:0]  o_color;
  logic                   hit;

  assign hit = (h_req.typ == REQ_SHADE) && h_draw && (texel[31:24] > ALPHA_MIN);

  always_ff @(posedge clk) begin
    if (adv) begin
      o_write <= hit;
      o_x     <= h_req.px;
      o_y     <= h_req.py;
      o_color <= hit ? {ALPHA_OPAQUE, shade(texel[23:16], h_req.br),
                        shade(texel[15:8], h_req.br), shade(texel[7:0], h_req.br)}
                     : '0;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
      f_v <= 1'b0;
      for (int i = 0; i < QW; i++) begin
        dly_v[i] <= 1'b0;
      end
      h_v <= 1'b0;
      o_v <= 1'b0;
    end else if (adv) begin
      a_v      <= s_tvalid;
      b_v      <= a_v;
      c_v      <= b_v;
      d_v      <= c_v;
      e_v      <= d_v;
      f_v      <= e_v;
      dly_v[0] <= f_v;
      for (int i = 1; i < QW; i++) begin
        dly_v[i] <= dly_v[i-1];
      end
      h_v <= g_v;
      o_v <= h_v;
    end
  end

  assign m_tvalid = o_v;
  assign m_tuser  = o_write;
  assign m_tdata  = {4'b0, o_color, o_y, o_x};

endmodule

>>> tb/sv/tb_affine_textured_quad_shader.sv
// ---------------------------------------------------------------------------
// tb_affine_textured_quad_shader: stream testbench of the textured quad shader
// loads textures, shades pixels over random quads and compares every result
// with an internal fixed-point model of the affine lookup
// ---------------------------------------------------------------------------
module tb_affine_textured_quad_shader
  import atqs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 4096;
  localparam int TEX_SIDE    = 64;
  localparam int LATENCY     = 8 + 6;
  localparam int STALL_LIMIT = 20000;

  logic         clk;
  logic         rst;
  // pixel_x, pixel_y, texel_index, texel_color, origin_x, origin_y,
  // edge_u_end_x, edge_u_end_y, edge_v_end_x, edge_v_end_y, brightness
  logic [167:0] s_tdata;
  // req_type
  logic         s_tuser;
  logic         s_tvalid;
  logic         s_tready;
  // out_x, out_y, out_color, zero pad
  logic [55:0]  m_tdata;
  // pixel_write
  logic         m_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [6:0]   cfg_data;

  affine_textured_quad_shader dut (.*);

  // one request, texel write or shade
  typedef struct {
    logic                 kind;
    logic [9:0]           px, py;
    logic [11:0]          idx;
    logic [31:0]          col;
    logic signed [15:0]   ox, oy, ux, uy, vx, vy;
    logic [7:0]           br;
  } shade_req_t;

  // one expected fragment
  typedef struct {
    logic        wr;
    logic [9:0]  x, y;
    logic [31:0] color;
  } fragment_t;

  // model copy of the texture and the size registers
  logic [31:0] tex_mem [STORE_DEPTH];
  bit          tex_known [STORE_DEPTH];
  logic [6:0]  tex_w_reg, tex_h_reg;
  fragment_t   pending_frags[$];

  int  errors, sent, checked, drawn, quiet_cycles;
  int  send_idle_pct, recv_idle_pct;
  bit  hold_off;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int clamp_size(logic [6:0] r);
    if (r < 7'd1) return 1;
    if (int'(r) > TEX_SIDE) return TEX_SIDE;
    return int'(r);
  endfunction

  function automatic logic [7:0] scale_channel(logic [7:0] ch, logic [7:0] br);
    return 8'((int'(ch) * int'(br)) / 255);
  endfunction

  // texel address the quad lookup reaches, or -1 when nothing is drawn
  function automatic longint lookup_addr(shade_req_t r);
    longint e0x, e0y, e1x, e1y, det, adet, dx, dy, nu, nv, w, h, sx, sy;
    e0x = longint'(r.ux) - longint'(r.ox);
    e0y = longint'(r.uy) - longint'(r.oy);
    e1x = longint'(r.vx) - longint'(r.ox);
    e1y = longint'(r.vy) - longint'(r.oy);
    det = e0x * e1y - e0y * e1x;
    adet = det < 0 ? -det : det;
    if (adet * 1000 < longint'(1 << (2 * FRAC_BITS))) return -1;
    dx = (longint'(r.px) << FRAC_BITS) - longint'(r.ox);
    dy = (longint'(r.py) << FRAC_BITS) - longint'(r.oy);
    nu = dx * e1y - dy * e1x;
    nv = e0x * dy - e0y * dx;
    if (det < 0) begin
      nu = -nu;
      nv = -nv;
    end
    if (!(50 * nu >= -adet && 50 * nu <= 51 * adet &&
          50 * nv >= -adet && 50 * nv <= 51 * adet)) return -1;
    w = longint'(clamp_size(tex_w_reg));
    h = longint'(clamp_size(tex_h_reg));
    nu = nu < 0 ? 0 : (nu > adet ? adet : nu);
    nv = nv < 0 ? 0 : (nv > adet ? adet : nv);
    sx = nu * (w - 1) / adet;
    sy = nv * (h - 1) / adet;
    if (sx > w - 1) sx = w - 1;
    if (sy > h - 1) sy = h - 1;
    return sy * w + sx;
  endfunction

  // expected fragment for one accepted request, updating the texture copy
  function automatic fragment_t predict_fragment(shade_req_t r);
    fragment_t f;
    longint    a;
    logic [31:0] t;
    f.x = r.px;  f.y = r.py;  f.wr = 1'b0;  f.color = '0;
    if (r.kind == REQ_WRITE) begin
      tex_mem[r.idx] = r.col;
      tex_known[r.idx] = 1'b1;
    end else begin
      a = lookup_addr(r);
      if (a >= 0) begin
        t = tex_mem[a];
        if (t[31:24] > ALPHA_MIN) begin
          f.wr = 1'b1;
          f.color = {ALPHA_OPAQUE, scale_channel(t[23:16], r.br),
                     scale_channel(t[15:8], r.br), scale_channel(t[7:0], r.br)};
        end
      end
    end
    return f;
  endfunction

  // offer one request until it transfers; valid stays up for a following one
  task automatic send_request(shade_req_t r);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tuser  <= r.kind;
    s_tdata  <= {r.br, r.vy, r.vx, r.uy, r.ux, r.oy, r.ox, r.col, r.idx, r.py, r.px};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_frags.push_back(predict_fragment(r));
    sent++;
  endtask

  function automatic shade_req_t texel_write(int idx, logic [31:0] col);
    shade_req_t r;
    r = '{default: '0};
    r.kind = REQ_WRITE;
    r.idx = 12'(idx);
    r.col = col;
    r.px = 10'($urandom);
    r.py = 10'($urandom);
    return r;
  endfunction

  // random shade on a quad around the pixel, or with fully random corners when wild;
  // shade_batch skips any shade whose lookup would hit an unloaded texel
  function automatic shade_req_t random_shade(bit wild);
    shade_req_t r;
    int cx, cy, s;
    r = '{default: '0};
    r.kind = REQ_SHADE;
    r.br = 8'($urandom);
    r.px = 10'($urandom);
    r.py = 10'($urandom);
    if (wild) begin
      {r.ox, r.oy, r.ux, r.uy} = {$urandom, $urandom};
      {r.vx, r.vy} = $urandom;
    end else begin
      s = int'($urandom_range(2, 200));
      cx = int'(r.px) * 16 - int'($urandom_range(0, s * 16));
      cy = int'(r.py) * 16 - int'($urandom_range(0, s * 16));
      r.ox = 16'(cx);
      r.oy = 16'(cy);
      r.ux = 16'(cx + s * 16 + int'($urandom_range(0, 64)) - 32);
      r.uy = 16'(cy + int'($urandom_range(0, 64)) - 32);
      r.vx = 16'(cx + int'($urandom_range(0, 64)) - 32);
      r.vy = 16'(cy + s * 16 + int'($urandom_range(0, 64)) - 32);
      if ($urandom_range(1)) {r.ux, r.uy, r.vx, r.vy} = {r.vx, r.vy, r.ux, r.uy};
    end
    return r;
  endfunction

  function automatic bit bool_lookup_safe(shade_req_t r);
    longint a;
    a = lookup_addr(r);
    return a < 0 || tex_known[a];
  endfunction

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_frags.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_size(logic [1:0] which, logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (which == REG_TEX_WIDTH) tex_w_reg = val;
    else tex_h_reg = val;
    @(posedge clk);
  endtask

  // texture entries of the active size not loaded yet, random colors with
  // alpha around the limit
  task automatic load_texture;
    int n;
    n = clamp_size(tex_w_reg) * clamp_size(tex_h_reg);
    for (int i = 0; i < n; i++) begin
      if (!tex_known[i])
        send_request(texel_write(i, {8'($urandom_range(0, 3) == 0 ?
                                      $urandom_range(0, 11) : $urandom),
                                     24'($urandom)}));
    end
  endtask

  task automatic shade_batch(int count);
    shade_req_t r;
    int done;
    done = 0;
    while (done < count) begin
      r = random_shade($urandom_range(0, 9) == 0);
      if (!bool_lookup_safe(r)) continue;
      send_request(r);
      done++;
    end
  endtask

  // extremes: corners of the quad, a degenerate quad, texels at the alpha limit,
  // a write outside the active texture, full brightness and zero
  task automatic test_directed;
    shade_req_t r;
    tex_w_reg = 7'd16;
    tex_h_reg = 7'd16;
    load_texture();
    send_request(texel_write(4095, 32'hFFFF_FFFF));
    send_request(texel_write(0, 32'hFF80_40FF));
    send_request(texel_write(255, 32'h0BFF_FFFF));
    send_request(texel_write(15, 32'h0A12_3456));
    r = '{default: '0};
    r.kind = REQ_SHADE;
    r.ox = 16'sd0; r.oy = 16'sd0; r.ux = 16'sd1600; r.uy = 16'sd0;
    r.vx = 16'sd0; r.vy = 16'sd1600;
    for (int k = 0; k < 8; k++) begin
      r.br = k[0] ? 8'hFF : 8'h00;
      r.px = k[1] ? 10'd100 : 10'd0;
      r.py = k[2] ? 10'd100 : 10'd0;
      send_request(r);
    end
    r.br = 8'd77; r.px = 10'd101; r.py = 10'd50;
    send_request(r);
    r.px = 10'd1023; r.py = 10'd1023;
    send_request(r);
    // a degenerate quad with collinear edges, then a quad at the coordinate extremes
    r.vx = 16'sd800; r.vy = 16'sd0; r.px = 10'd10; r.py = 10'd0;
    send_request(r);
    r = '{default: '0};
    r.kind = REQ_SHADE;
    r.ox = 16'sh8000; r.oy = 16'sh7FFF; r.ux = 16'sh7FFF; r.uy = 16'sh8000;
    r.vx = 16'sh8000; r.vy = 16'sh8000; r.br = 8'hFF; r.px = 10'h3FF;
    if (bool_lookup_safe(r)) send_request(r);
    drain();
  endtask

  // wide and narrow sizes in rotating pairs, including the clamped codes
  task automatic test_sizes;
    logic [6:0] sizes [6] = '{7'd64, 7'd127, 7'd37, 7'd0, 7'd1, 7'd2};
    for (int i = 0; i < 6; i++) begin
      write_size(REG_TEX_WIDTH, sizes[i]);
      write_size(REG_TEX_HEIGHT, sizes[(i + 3) % 6]);
      load_texture();
      shade_batch(40);
      drain();
    end
  endtask

  task automatic test_random;
    write_size(REG_TEX_WIDTH, 7'($urandom_range(1, 12)));
    write_size(REG_TEX_HEIGHT, 7'($urandom_range(1, 12)));
    load_texture();
    for (int i = 0; i < 30; i++) begin
      if ($urandom_range(4) == 0)
        send_request(texel_write(int'($urandom_range(0, 4095)), $urandom));
      else
        shade_batch(5);
    end
    drain();
  endtask

  // receiver parks for a long stretch while requests keep coming
  task automatic test_backpressure;
    hold_off = 1'b1;
    fork
      shade_batch(60);
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    hold_off = 1'b0;
    drain();
  endtask

  // receiver with its own random stalls
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !hold_off &&
                     !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  // result checker, one transfer per edge
  always @(posedge clk) begin
    fragment_t f;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_frags.size() == 0) begin
        $display("%0t: unexpected result %h user %b", $realtime, m_tdata, m_tuser);
        errors++;
      end else begin
        f = pending_frags.pop_front();
        checked++;
        if (f.wr) drawn++;
        if (m_tuser !== f.wr || m_tdata !== {4'b0000, f.color, f.y, f.x}) begin
          $display("%0t: mismatch expected wr %b x %0d y %0d color %h,",
                   $realtime, f.wr, f.x, f.y, f.color,
                   " got wr %b x %0d y %0d color %h",
                   m_tuser, m_tdata[9:0], m_tdata[19:10], m_tdata[51:20]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("[affine_textured_quad_shader] ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0; s_tuser = 1'b0; s_tdata = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    hold_off = 1'b0; errors = 0; sent = 0; checked = 0; drawn = 0; quiet_cycles = 0;
    send_idle_pct = 33; recv_idle_pct = 85;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_sizes();
    send_idle_pct = 85; recv_idle_pct = 33;
    test_random();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random();
    test_backpressure();
    $display("covered %0d requests, %0d results checked, %0d pixels drawn",
             sent, checked, drawn);
    $display("texture sizes 0..127 incl. clamp, degenerate and outside quads, stalls");
    if (errors == 0 && pending_frags.size() == 0)
      $display("[affine_textured_quad_shader] OK");
    else
      $display("[affine_textured_quad_shader] ERROR");
    $finish;
  end

endmodule
